>>> rtl/trc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

	// capture geometry
	localparam int CAP_BYTES    = 8;
	localparam int CAP_AGE_BITS = $clog2(CAP_BYTES);
	localparam int WIN_BITS     = CAP_BYTES * 8;
	localparam int CELLS        = CAP_BYTES - 1;
	localparam int SKIP_BITS    = 3;
	localparam int TYPE_BITS    = 4;
	localparam int NUM_TYPES    = 1 << TYPE_BITS;

	// configuration registers
	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CAPTURE_LIMIT     = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CAPTURE_TYPE_MASK = 1'b1;
	localparam logic [CFG_BITS-1:0] LIMIT_RESET = 16'hFFFF;
	localparam logic [CFG_BITS-1:0] MASK_RESET  = 16'h81A4;

	// bytes still to skip after a token's first byte, by token type
	localparam logic [SKIP_BITS-1:0] SKIP_TABLE [NUM_TYPES] = '{
		3'd1, 3'd7, 3'd7, 3'd3, 3'd1, 3'd5, 3'd1, 3'd1,
		3'd1, 3'd1, 3'd1, 3'd7, 3'd5, 3'd3, 3'd7, 3'd5
	};

	// window snapshot handed from the cell row to the drain unit
	typedef struct packed {
		logic [WIN_BITS-1:0]  window;
		logic [CAP_BYTES-1:0] due;
		logic                 last;
	} snap_t;

endpackage

`default_nettype wire

>>> rtl/trace_token_rare_capture.sv
`timescale 1ns / 1ps
`default_nettype none
// path: a capture passes the drain unit's snapshot register, then the output register
// throughput: one byte per cycle while the drain is ready; due captures drain one at a time
// a last byte with pending captures holds the input while all but the last of them drain
// reset: asynchronous, clears marks, skip count, offset, capture count and valid flags;
// window bytes and stored offsets are payload and are never read before being written

module trace_token_rare_capture #(
	parameter int OFFSET_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [7:0]                       byte_value,
	input  wire logic                             last_byte,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [trc_pkg::WIN_BITS-1:0]          contents,
	output logic [trc_pkg::TYPE_BITS-1:0]         token_type,
	output logic [OFFSET_BITS-1:0]                byte_offset,
	output logic                                  run_last,
	input  wire logic                             cfg_wr_en,
	input  wire logic [trc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [trc_pkg::CFG_BITS-1:0]     cfg_wdata
);
	import trc_pkg::*;

	logic [CFG_BITS-1:0]    limit_q;
	logic [CFG_BITS-1:0]    mask_q;
	logic [SKIP_BITS-1:0]   skip_q;
	logic [OFFSET_BITS-1:0] stream_off_q;

	logic                   in_acc;
	logic                   tok_start;
	logic [TYPE_BITS-1:0]   tok_type;
	logic                   new_mark;
	logic                   drain_ready;

	logic [7:0]             cell_byte_d [CELLS];
	logic                   cell_mark_d [CELLS];
	logic [OFFSET_BITS-1:0] cell_off_d  [CELLS];
	logic [7:0]             cell_byte   [CELLS];
	logic                   cell_mark   [CELLS];
	logic [OFFSET_BITS-1:0] cell_off    [CELLS];
	logic [CELLS-1:0]       chain_marks;

	logic [7:0]             view_byte [CAP_BYTES];
	logic [CAP_BYTES-1:0]   view_mark;
	logic [OFFSET_BITS-1:0] view_off  [CAP_BYTES];
	snap_t                  snap;
	logic                   snap_load;
	logic                   cnt_clear;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			mask_q  <= MASK_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CAPTURE_LIMIT:     limit_q <= cfg_wdata;
				REG_CAPTURE_TYPE_MASK: mask_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = !drain_ready;
	assign tok_start = skip_q == '0;
	assign tok_type  = byte_value[TYPE_BITS-1:0];
	assign new_mark  = tok_start && mask_q[tok_type];

	// token length tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
		end else if (in_acc) begin
			if (last_byte) begin
				skip_q <= '0;
			end else if (tok_start) begin
				skip_q <= SKIP_TABLE[tok_type];
			end else begin
				skip_q <= skip_q - 3'd1;
			end
		end
	end

	// saturating stream offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_off_q <= '0;
		end else if (in_acc) begin
			if (last_byte) begin
				stream_off_q <= '0;
			end else if (stream_off_q != '1) begin
				stream_off_q <= stream_off_q + 1'b1;
			end
		end
	end

	// neighbor feeds of the cell row
	always_comb begin
		for (int i = 0; i < CELLS; i++) begin
			if (i == 0) begin
				cell_byte_d[i] = byte_value;
				cell_mark_d[i] = new_mark;
				cell_off_d[i]  = stream_off_q;
			end else begin
				cell_byte_d[i] = cell_byte[i-1];
				cell_mark_d[i] = cell_mark[i-1];
				cell_off_d[i]  = cell_off[i-1];
			end
		end
	end

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		trc_cell #(
			.OFF_BITS (OFFSET_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (in_acc),
			.clear  (last_byte),
			.byte_d (cell_byte_d[g]),
			.mark_d (cell_mark_d[g]),
			.off_d  (cell_off_d[g]),
			.byte_q (cell_byte[g]),
			.mark_q (cell_mark[g]),
			.off_q  (cell_off[g])
		);
		assign chain_marks[g] = cell_mark[g];
	end

	// window as it stands once this item is taken in
	always_comb begin
		for (int j = 0; j < CAP_BYTES; j++) begin
			if (j == 0) begin
				view_byte[j] = byte_value;
				view_mark[j] = new_mark;
				view_off[j]  = stream_off_q;
			end else begin
				view_byte[j] = cell_byte[j-1];
				view_mark[j] = cell_mark[j-1];
				view_off[j]  = cell_off[j-1];
			end
		end
	end

	// snapshot for the drain unit: full captures, or everything at stream end
	always_comb begin
		for (int k = 0; k < CAP_BYTES; k++) begin
			snap.window[8*k +: 8] = view_byte[CAP_BYTES-1-k];
		end
		snap.due  = last_byte ? view_mark
		                      : (view_mark & {1'b1, {(CAP_BYTES-1){1'b0}}});
		snap.last = last_byte;
	end

	assign snap_load = in_acc && (snap.due != '0);
	assign cnt_clear = in_acc && last_byte && (snap.due == '0);

	trc_drain #(
		.OFF_BITS (OFFSET_BITS)
	) u_drain (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (snap_load),
		.snap        (snap),
		.snap_off    (view_off),
		.cnt_clear   (cnt_clear),
		.limit       (limit_q),
		.ready       (drain_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.contents    (contents),
		.token_type  (token_type),
		.byte_offset (byte_offset),
		.run_last    (run_last)
	);

	a_stream_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_byte |=> skip_q == '0 && stream_off_q == '0 && chain_marks == '0)
		else $error("stream state not cleared after last item");

	a_marks_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(chain_marks) <= 4)
		else $error("too many pending captures in cell row");

	a_skip_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !last_byte && !tok_start |=> skip_q == $past(skip_q) - 3'd1)
		else $error("skip count did not step down");

endmodule

`default_nettype wire

>>> rtl/trc_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module trc_cell #(
	parameter int OFF_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire logic                clear,
	input  wire logic [7:0]          byte_d,
	input  wire logic                mark_d,
	input  wire logic [OFF_BITS-1:0] off_d,
	output logic      [7:0]          byte_q,
	output logic                     mark_q,
	output logic      [OFF_BITS-1:0] off_q
);

	// pending capture mark, dropped at stream end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
		end else if (shift) begin
			mark_q <= clear ? 1'b0 : mark_d;
		end
	end

	// byte and token start offset move along with the mark
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_d;
			off_q  <= off_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/trc_drain.sv
`timescale 1ns / 1ps
`default_nettype none

module trc_drain #(
	parameter int OFF_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire trc_pkg::snap_t                snap,
	input  wire logic [OFF_BITS-1:0]           snap_off [trc_pkg::CAP_BYTES],
	input  wire logic                          cnt_clear,
	input  wire logic [trc_pkg::CFG_BITS-1:0]  limit,
	output logic                               ready,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [trc_pkg::WIN_BITS-1:0]       contents,
	output logic [trc_pkg::TYPE_BITS-1:0]      token_type,
	output logic [OFF_BITS-1:0]                byte_offset,
	output logic                               run_last
);
	import trc_pkg::*;

	logic                    snap_valid_q;
	logic [CAP_BYTES-1:0]    due_q;
	logic                    last_q;
	logic [WIN_BITS-1:0]     win_q;
	logic [OFF_BITS-1:0]     off_q [CAP_BYTES];
	logic [CFG_BITS-1:0]     emitted_q;
	logic [CAP_AGE_BITS-1:0] age;
	logic [CAP_BYTES-1:0]    rest;
	logic                    rest_any;
	logic                    allow;
	logic                    more;
	logic                    out_free;
	logic                    step;

	// oldest pending capture first
	always_comb begin
		age = '0;
		for (int i = 0; i < CAP_BYTES; i++) begin
			if (due_q[i]) age = CAP_AGE_BITS'(i);
		end
	end

	assign rest     = due_q & ~({{(CAP_BYTES-1){1'b0}}, 1'b1} << age);
	assign rest_any = |rest;
	assign allow    = emitted_q < limit;
	assign more     = rest_any && (({1'b0, emitted_q} + 17'd1) < {1'b0, limit});
	assign out_free = !out_valid || !out_stall;
	assign step     = snap_valid_q && (!allow || out_free);
	assign ready    = !snap_valid_q || (step && !rest_any);

	// snapshot control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_q <= 1'b0;
			due_q        <= '0;
			last_q       <= 1'b0;
		end else if (load) begin
			snap_valid_q <= 1'b1;
			due_q        <= snap.due;
			last_q       <= snap.last;
		end else if (step) begin
			snap_valid_q <= rest_any;
			due_q        <= rest;
		end
	end

	// snapshot payload
	always_ff @(posedge clk) begin
		if (load) begin
			win_q <= snap.window;
			off_q <= snap_off;
		end
	end

	// captures emitted in this stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitted_q <= '0;
		end else if (cnt_clear) begin
			emitted_q <= '0;
		end else if (step) begin
			if (!rest_any && last_q) begin
				emitted_q <= '0;
			end else if (allow) begin
				emitted_q <= emitted_q + 16'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step && allow) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// window bytes from the token start, oldest byte lowest
	always_ff @(posedge clk) begin
		if (step && allow) begin
			contents    <= win_q >> {~age, 3'b000};
			token_type  <= win_q[{~age, 3'b000} +: TYPE_BITS];
			byte_offset <= off_q[age];
			run_last    <= !more;
		end
	end

	a_snap_has_due: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid_q |-> due_q != '0)
		else $error("drain snapshot held with nothing due");

	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		step && !rest_any && last_q |=> emitted_q == '0)
		else $error("capture count not cleared at stream end");

	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("snapshot loaded while drain busy");

endmodule

`default_nettype wire
